FILE: design/rwnh_pkg.sv
package rwnh_pkg;

   localparam int FRAC_BITS = 8;
   localparam int COORD_W   = 16;
   localparam int DIR_W     = 10;
   localparam int DIFF_W    = 17;
   localparam int PROD_W    = 19;
   localparam int CROSS_W   = 20;
   localparam int SQ_W      = 24;
   localparam int DIST_W    = 25;
   localparam int SPAN_W    = 21;
   localparam int DEPTH_W   = 28;
   localparam int COLOUR_W  = 15;
   localparam int COUNT_W   = 7;
   localparam int INDEX_W   = 6;

   localparam logic [DEPTH_W-1:0] NONE_DEPTH = 28'd256000000;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   typedef struct packed {
      logic [COLOUR_W-1:0]       colour;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_x;
   } wall_type;

   typedef struct packed {
      logic                hit;
      logic [DIST_W-1:0]   sdist;
      logic [DIST_W-1:0]   edist;
      logic [COLOUR_W-1:0] colour;
   } div_side_type;

   typedef struct packed {
      logic valid;
      logic busy;
   } div_stat_type;

endpackage

FILE: design/rwnh_if.sv
interface rwnh_req_if;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [5:0]               wall_index;
   logic signed [15:0]       wall_start_x;
   logic signed [15:0]       wall_start_y;
   logic signed [15:0]       wall_end_x;
   logic signed [15:0]       wall_end_y;
   logic [14:0]              wall_colour;
   logic signed [15:0]       ray_origin_x;
   logic signed [15:0]       ray_origin_y;
   logic signed [9:0]        ray_dir_x;
   logic signed [9:0]        ray_dir_y;

   modport source (output valid, operation, wall_index, wall_start_x, wall_start_y,
                   wall_end_x, wall_end_y, wall_colour, ray_origin_x, ray_origin_y,
                   ray_dir_x, ray_dir_y, input ready);
   modport sink (input valid, operation, wall_index, wall_start_x, wall_start_y,
                 wall_end_x, wall_end_y, wall_colour, ray_origin_x, ray_origin_y,
                 ray_dir_x, ray_dir_y, output ready);
endinterface

interface rwnh_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit_found;
   logic [27:0] hit_depth;
   logic [14:0] hit_colour;

   modport source (output valid, hit_found, hit_depth, hit_colour, input ready);
   modport sink (input valid, hit_found, hit_depth, hit_colour, output ready);
endinterface

interface rwnh_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] wall_count;

   modport source (output valid, wall_count, input ready);
   modport sink (input valid, wall_count, output ready);
endinterface

FILE: design/rwnh_div.sv
module rwnh_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rwnh_pkg::SPAN_W-1:0]   in_num,
   input  logic [rwnh_pkg::SPAN_W-1:0]   in_den,
   input  rwnh_pkg::div_side_type        in_side,
   output rwnh_pkg::div_stat_type        out_stat,
   output logic [rwnh_pkg::FRAC_BITS-1:0] out_quot,
   output rwnh_pkg::div_side_type        out_side
);

   localparam int Q = rwnh_pkg::FRAC_BITS;
   localparam int W = rwnh_pkg::SPAN_W;

   logic [W-1:0]           rem_ff  [0:Q-1];
   logic [W-1:0]           den_ff  [0:Q-1];
   logic [Q-1:0]           quot_ff [0:Q-1];
   rwnh_pkg::div_side_type side_ff [0:Q-1];
   logic [Q-1:0]           valid_ff;

   logic [W-1:0]           rem_src  [0:Q-1];
   logic [W-1:0]           den_src  [0:Q-1];
   logic [Q-1:0]           quot_src [0:Q-1];
   rwnh_pkg::div_side_type side_src [0:Q-1];
   logic [Q-1:0]           valid_src;
   logic [W-1:0]           rem_in   [0:Q-1];
   logic [Q-1:0]           quot_in  [0:Q-1];

   // one quotient bit per stage; remainder stays below the divisor while the numerator is below it
   always_comb begin
      logic [W:0] shifted;
      logic       ge;
      rem_src[0]   = in_num;
      den_src[0]   = in_den;
      quot_src[0]  = '0;
      side_src[0]  = in_side;
      valid_src[0] = in_valid;
      for (int k = 1; k < Q; k++) begin
         rem_src[k]   = rem_ff[k-1];
         den_src[k]   = den_ff[k-1];
         quot_src[k]  = quot_ff[k-1];
         side_src[k]  = side_ff[k-1];
         valid_src[k] = valid_ff[k-1];
      end
      for (int k = 0; k < Q; k++) begin
         shifted    = {rem_src[k], 1'b0};
         ge         = shifted >= {1'b0, den_src[k]};
         rem_in[k]  = ge ? W'(shifted - {1'b0, den_src[k]}) : W'(shifted);
         quot_in[k] = {quot_src[k][Q-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Q; k++) begin
         rem_ff[k]  <= rem_in[k];
         den_ff[k]  <= den_src[k];
         quot_ff[k] <= quot_in[k];
         side_ff[k] <= side_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_src;
      end
   end

   assign out_stat.valid = valid_ff[Q-1];
   assign out_stat.busy  = |valid_ff;
   assign out_quot       = quot_ff[Q-1];
   assign out_side       = side_ff[Q-1];

endmodule

FILE: design/ray_wall_nearest_hit_unit.sv
// Channel   Port     Dir  Word
// request   req_bus  in   write wall entry, or cast ray
// response  rsp_bus  out  hit_found, hit_depth, hit_colour (one per cast)
// control   csr_bus  in   wall_count
//
// A cast reads n = min(wall_count, MAX_WALLS) wall entries; no new word is taken until
// its result shows. The wall table memory gives one entry a cycle, and a pipeline (8 of
// its stages the divider) and the nearest-hit compare follow it. Reset is synchronous
// and clears control state only; the wall table holds garbage until written. A finished
// result waits in the output register while the next word is taken; a cast then holds
// before reporting.
module ray_wall_nearest_hit_unit #(
   parameter int MAX_WALLS = 64
) (
   input  logic              clock,
   input  logic              reset,
   rwnh_req_if.sink          req_bus,
   rwnh_rsp_if.source        rsp_bus,
   rwnh_csr_if.sink          csr_bus
);

   localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
   localparam int CW = $clog2(MAX_WALLS + 1);
   localparam int FB = rwnh_pkg::FRAC_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CAST  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [rwnh_pkg::COUNT_W-1:0] wall_count_ff;

   logic signed [rwnh_pkg::COORD_W-1:0] org_x_ff, org_y_ff;
   logic signed [rwnh_pkg::DIR_W-1:0]   dir_x_ff, dir_y_ff;

   rwnh_pkg::wall_type mem [0:MAX_WALLS-1];
   rwnh_pkg::wall_type rd_ff;
   logic               s1_valid_ff;

   logic req_take, rd_en, last_idx, pipe_busy;
   logic [CW-1:0] n_walls;

   // stage 2: differences from origin
   logic signed [rwnh_pkg::DIFF_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [rwnh_pkg::COLOUR_W-1:0]      s2_colour_ff;
   logic                               s2_valid_ff;

   // stage 3: products
   logic signed [rwnh_pkg::PROD_W-1:0] p_ff [0:7];
   logic [rwnh_pkg::SQ_W-1:0]          q_ff [0:3];
   logic [rwnh_pkg::COLOUR_W-1:0]      s3_colour_ff;
   logic                               s3_valid_ff;
   logic signed [rwnh_pkg::PROD_W-1:0] p_in [0:7];
   logic [rwnh_pkg::SQ_W-1:0]          q_in [0:3];

   // stage 4: sums
   logic signed [rwnh_pkg::CROSS_W-1:0] sc_ff, ec_ff, sd_ff, ed_ff;
   logic [rwnh_pkg::DIST_W-1:0]         sdist_ff, edist_ff;
   logic [rwnh_pkg::COLOUR_W-1:0]       s4_colour_ff;
   logic                                s4_valid_ff;

   logic                          hit;
   logic [rwnh_pkg::SPAN_W-1:0]   mag_s, mag_e, span;
   rwnh_pkg::div_side_type        div_side_in, div_side_out;
   rwnh_pkg::div_stat_type        div_stat;
   logic [FB-1:0]                 part;

   // stage 5: weighted distances
   logic [rwnh_pkg::DIST_W-1:0]   wa_ff, wb_ff;
   logic                          s5_hit_ff;
   logic [rwnh_pkg::COLOUR_W-1:0] s5_colour_ff;
   logic                          s5_valid_ff;

   logic [rwnh_pkg::DEPTH_W-1:0]  depth_sum, depth;
   logic                          found_ff;
   logic [rwnh_pkg::DEPTH_W-1:0]  best_ff;
   logic [rwnh_pkg::COLOUR_W-1:0] best_colour_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_found_ff;
   logic [rwnh_pkg::DEPTH_W-1:0]  rsp_depth_ff;
   logic [rwnh_pkg::COLOUR_W-1:0] rsp_colour_ff;
   logic                          rsp_load;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      if (32'(wall_count_ff) > MAX_WALLS) begin
         n_walls = CW'(MAX_WALLS);
      end else begin
         n_walls = CW'(wall_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_count_ff <= '0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         wall_count_ff <= csr_bus.wall_count;
      end
   end

   // sequencer
   assign rd_en    = (state_ff == ST_CAST);
   assign last_idx = (CW'(idx_ff) + CW'(1)) == cnt_ff;
   assign pipe_busy = s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff
                      || div_stat.busy || s5_valid_ff;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_bus.operation == rwnh_pkg::OP_CAST) begin
               idx_in   = '0;
               cnt_in   = n_walls;
               state_in = (n_walls == '0) ? ST_DRAIN : ST_CAST;
            end
         end
         ST_CAST: begin
            idx_in = idx_ff + AW'(1);
            if (last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_bus.operation == rwnh_pkg::OP_CAST) begin
         org_x_ff <= req_bus.ray_origin_x;
         org_y_ff <= req_bus.ray_origin_y;
         dir_x_ff <= req_bus.ray_dir_x;
         dir_y_ff <= req_bus.ray_dir_y;
      end
   end

   // wall table: write on a write word, read one entry a cycle during a cast
   always_ff @(posedge clock) begin
      if (req_take && req_bus.operation == rwnh_pkg::OP_WRITE
          && 32'(req_bus.wall_index) < MAX_WALLS) begin
         mem[AW'(req_bus.wall_index)] <= '{colour:  req_bus.wall_colour,
                                           end_y:   req_bus.wall_end_y,
                                           end_x:   req_bus.wall_end_x,
                                           start_y: req_bus.wall_start_y,
                                           start_x: req_bus.wall_start_x};
      end
      if (rd_en) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      sx_ff        <= rwnh_pkg::DIFF_W'(rd_ff.start_x) - rwnh_pkg::DIFF_W'(org_x_ff);
      sy_ff        <= rwnh_pkg::DIFF_W'(rd_ff.start_y) - rwnh_pkg::DIFF_W'(org_y_ff);
      ex_ff        <= rwnh_pkg::DIFF_W'(rd_ff.end_x) - rwnh_pkg::DIFF_W'(org_x_ff);
      ey_ff        <= rwnh_pkg::DIFF_W'(rd_ff.end_y) - rwnh_pkg::DIFF_W'(org_y_ff);
      s2_colour_ff <= rd_ff.colour;
   end

   // products, each floored to Q.8
   always_comb begin
      logic signed [26:0] cp [0:7];
      logic signed [33:0] sq [0:3];
      cp[0] = 27'(sx_ff) * 27'(dir_y_ff);
      cp[1] = 27'(sy_ff) * 27'(dir_x_ff);
      cp[2] = 27'(ex_ff) * 27'(dir_y_ff);
      cp[3] = 27'(ey_ff) * 27'(dir_x_ff);
      cp[4] = 27'(dir_x_ff) * 27'(sx_ff);
      cp[5] = 27'(dir_y_ff) * 27'(sy_ff);
      cp[6] = 27'(dir_x_ff) * 27'(ex_ff);
      cp[7] = 27'(dir_y_ff) * 27'(ey_ff);
      sq[0] = 34'(sx_ff) * 34'(sx_ff);
      sq[1] = 34'(sy_ff) * 34'(sy_ff);
      sq[2] = 34'(ex_ff) * 34'(ex_ff);
      sq[3] = 34'(ey_ff) * 34'(ey_ff);
      for (int k = 0; k < 8; k++) begin
         p_in[k] = rwnh_pkg::PROD_W'(cp[k] >>> FB);
      end
      for (int k = 0; k < 4; k++) begin
         q_in[k] = rwnh_pkg::SQ_W'(sq[k] >>> FB);
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      q_ff         <= q_in;
      s3_colour_ff <= s2_colour_ff;
   end

   always_ff @(posedge clock) begin
      sc_ff        <= rwnh_pkg::CROSS_W'(p_ff[0]) - rwnh_pkg::CROSS_W'(p_ff[1]);
      ec_ff        <= rwnh_pkg::CROSS_W'(p_ff[2]) - rwnh_pkg::CROSS_W'(p_ff[3]);
      sd_ff        <= rwnh_pkg::CROSS_W'(p_ff[4]) + rwnh_pkg::CROSS_W'(p_ff[5]);
      ed_ff        <= rwnh_pkg::CROSS_W'(p_ff[6]) + rwnh_pkg::CROSS_W'(p_ff[7]);
      sdist_ff     <= rwnh_pkg::DIST_W'(q_ff[0]) + rwnh_pkg::DIST_W'(q_ff[1]);
      edist_ff     <= rwnh_pkg::DIST_W'(q_ff[2]) + rwnh_pkg::DIST_W'(q_ff[3]);
      s4_colour_ff <= s3_colour_ff;
   end

   // endpoints strictly on opposite sides, at least one in front
   always_comb begin
      hit = ((sc_ff < 0 && ec_ff > 0) || (sc_ff > 0 && ec_ff < 0))
            && (sd_ff > 0 || ed_ff > 0);
      mag_s = (sc_ff < 0) ? rwnh_pkg::SPAN_W'(-sc_ff) : rwnh_pkg::SPAN_W'(sc_ff);
      mag_e = (ec_ff < 0) ? rwnh_pkg::SPAN_W'(-ec_ff) : rwnh_pkg::SPAN_W'(ec_ff);
      span  = mag_s + mag_e;
      div_side_in = '{hit: hit, sdist: sdist_ff, edist: edist_ff, colour: s4_colour_ff};
   end

   rwnh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s4_valid_ff),
      .in_num   (mag_s),
      .in_den   (span),
      .in_side  (div_side_in),
      .out_stat (div_stat),
      .out_quot (part),
      .out_side (div_side_out)
   );

   always_ff @(posedge clock) begin
      wa_ff <= rwnh_pkg::DIST_W'((33'(part) * 33'(div_side_out.sdist)) >> FB);
      wb_ff <= rwnh_pkg::DIST_W'((34'((FB+1)'(1 << FB) - (FB+1)'(part))
                                  * 34'(div_side_out.edist)) >> FB);
      s5_hit_ff    <= div_side_out.hit;
      s5_colour_ff <= div_side_out.colour;
   end

   always_comb begin
      depth_sum = rwnh_pkg::DEPTH_W'(wa_ff) + rwnh_pkg::DEPTH_W'(wb_ff);
      depth     = (depth_sum > rwnh_pkg::NONE_DEPTH) ? rwnh_pkg::NONE_DEPTH : depth_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= div_stat.valid;
      end
   end

   // keep the earlier wall on a tie
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff       <= 1'b0;
         best_ff        <= rwnh_pkg::NONE_DEPTH;
         best_colour_ff <= '0;
      end else if (req_take && req_bus.operation == rwnh_pkg::OP_CAST) begin
         found_ff       <= 1'b0;
         best_ff        <= rwnh_pkg::NONE_DEPTH;
         best_colour_ff <= '0;
      end else if (s5_valid_ff && s5_hit_ff) begin
         found_ff <= 1'b1;
         if (best_ff > depth) begin
            best_ff        <= depth;
            best_colour_ff <= s5_colour_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff  <= found_ff;
         rsp_depth_ff  <= best_ff;
         rsp_colour_ff <= found_ff ? best_colour_ff : '0;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hit_found  = rsp_found_ff;
   assign rsp_bus.hit_depth  = rsp_depth_ff;
   assign rsp_bus.hit_colour = rsp_colour_ff;

endmodule
